[design/rpcs_pkg.sv]
package rpcs_pkg;

    localparam int CHANNELS_DEF  = 4;
    localparam int TIME_BITS_DEF = 32;

    localparam int CAL_W   = 40;
    localparam int CFG_W   = 40;
    localparam int CFG_IDX_W = 3;
    localparam int DIV_W   = 64;
    localparam int MUL_W   = 33;

    localparam logic [CFG_IDX_W-1:0] CFG_CAL0     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL1     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL2     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CAL3     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RPM_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER    = 3'd5;

    localparam logic [CAL_W-1:0] CAL0_RESET  = 40'd192030057;
    localparam logic [CAL_W-1:0] CAL_RESET   = 40'd192030042;
    localparam logic [23:0]      POWER_RESET = 24'd7373800;

    localparam logic [31:0] WIN_LOW_CH0 = 32'd950;
    localparam logic [31:0] WIN_LOW     = 32'd700;
    localparam logic [31:0] WIN_HIGH    = 32'd2700;
    localparam logic signed [12:0] RAW_INVALID = -13'sd999;
    localparam logic signed [15:0] CH3_SCALE   = 16'sd11500;
    localparam logic [15:0] MOTOR_W_MAX = 16'd65535;
    localparam logic [5:0]  VOLT_SCALE  = 6'd50;
    localparam int POWER_FULL   = 2700;
    localparam int CUR_DEN_K    = 25;
    localparam int RPM_A_K      = 78125;
    localparam int RPM_N_K      = 37;
    localparam int RPM_DEN_K    = 128000;

    function automatic logic signed [31:0] sat32(input logic signed [DIV_W-1:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
        begin
            r = 32'sh7FFFFFFF;
        end
        else if (v < -64'sd2147483648)
        begin
            r = 32'sh80000000;
        end
        else
        begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

[design/rpcs_mul.sv]
module rpcs_mul (
    input  logic                                 clk,
    input  logic signed [rpcs_pkg::MUL_W-1:0]     a,
    input  logic signed [rpcs_pkg::MUL_W-1:0]     b,
    output logic signed [rpcs_pkg::DIV_W-1:0]     p_reg
);
    import rpcs_pkg::*;

    logic signed [2*MUL_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next[DIV_W-1:0];
    end

endmodule

[design/rpcs_div.sv]
module rpcs_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [rpcs_pkg::DIV_W-1:0]  num,
    input  logic signed [rpcs_pkg::DIV_W-1:0]  den,
    output logic                               done,
    output logic signed [rpcs_pkg::DIV_W-1:0]  quo
);
    import rpcs_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic               busy_reg, busy_next;
    logic               done_reg, done_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               neg_reg, neg_next;
    logic [DIV_W-1:0]   q_reg, q_next;
    logic [DIV_W-1:0]   d_reg, d_next;
    logic [DIV_W:0]     r_reg, r_next;
    logic [DIV_W:0]     r_sh;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        q_next    = q_reg;
        d_next    = d_reg;
        r_next    = r_reg;
        r_sh      = {r_reg[DIV_W-1:0], q_reg[DIV_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_W);
            neg_next  = num[DIV_W-1] ^ den[DIV_W-1];
            q_next    = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
            d_next    = den[DIV_W-1] ? DIV_W'(-den) : DIV_W'(den);
            r_next    = '0;
        end
        else if (busy_reg)
        begin
            if (r_sh >= {1'b0, d_reg})
            begin
                r_next = r_sh - {1'b0, d_reg};
                q_next = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                r_next = r_sh;
                q_next = {q_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        q_reg   <= q_next;
        d_reg   <= d_next;
        r_reg   <= r_next;
    end

    assign done = done_reg;
    assign quo  = neg_reg ? -$signed(q_reg) : $signed(q_reg);

endmodule

[design/rc_pulse_capture_and_scaling_core.sv]
// Rising and ignored edges give no beat; an out-of-window width gives its beat from S_FINISH once
// the output register is free. A servo pulse gives its beat after a multiply step, a divider
// start, the 64-step division and an output step.
// An rpm-mode pulse on channel 3 takes up to three divisions on the shared divider plus nine
// multiply and control steps. Input is ready again once the beat is loaded, while it waits.
// Reset (rst_n low, asynchronous) disarms all channels and restores register defaults.
module rc_pulse_capture_and_scaling_core #(
    parameter int CHANNELS  = rpcs_pkg::CHANNELS_DEF,
    parameter int TIME_BITS = rpcs_pkg::TIME_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,  // timestamp_us[31:0], adc_sample[41:32]
    input  logic [2:0]                      s_tuser,  // channel[1:0], level[2]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // raw_pulse[12:0], pulse_valid[13], angle[45:14], motor_voltage[61:46],
    // motor_power[93:62], motor_current[125:94], motor_rpm[157:126], math_fault[158]
    output logic [159:0]                    m_tdata,
    output logic [1:0]                      m_tuser,  // channel_out[1:0]
    input  logic                            cfg_we,
    input  logic [rpcs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [rpcs_pkg::CFG_W-1:0]      cfg_data
);
    import rpcs_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_A_MUL, S_A_DIV, S_A_WAIT,
        S_M_N, S_M_D, S_M_PDIV, S_M_PWAIT, S_M_CDIV, S_M_CWAIT,
        S_M_T2, S_M_T3, S_M_DIFF, S_M_X19, S_M_RWAIT, S_FINISH
    } state_t;

    state_t state_reg, state_next;

    logic [CAL_W-1:0]     cal_reg [4];
    logic                 rpm_mode_reg;
    logic [23:0]          power_reg;
    logic [CHANNELS-1:0]  armed_reg, armed_next;
    logic [TIME_BITS-1:0] start_reg [CHANNELS];

    logic [1:0]           ch_reg;
    logic [TIME_BITS-1:0] w_reg;
    logic [9:0]           adc_reg;
    logic                 valid_reg;
    logic signed [31:0]   angle_reg, power_out_reg, current_reg, rpm_reg;
    logic                 fault_reg;
    logic signed [DIV_W-1:0] n_reg, d_reg, t2_reg, diff_reg;

    logic                 out_valid_reg;
    logic [159:0]         out_data_reg;
    logic [1:0]           out_user_reg;

    logic [1:0]           in_ch;
    logic                 in_level;
    logic [TIME_BITS-1:0] in_ts;
    logic [9:0]           in_adc;
    logic [CH_W-1:0]      in_idx;
    logic                 in_acc;
    logic [TIME_BITS-1:0] in_w;
    logic [31:0]          in_w32;
    logic                 in_valid;

    logic [31:0]          w32;
    logic [11:0]          cz, cf;
    logic signed [15:0]   cg;
    logic signed [13:0]   wz_diff;
    logic signed [13:0]   span;
    logic [11:0]          pz, pm;
    logic signed [12:0]   rspan;
    logic [15:0]          wm;
    logic signed [17:0]   wm_diff;
    logic signed [12:0]   raw;
    logic [15:0]          volt;
    logic                 servo_fault, out_free;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [DIV_W-1:0] prod;
    logic                    div_start, div_done;
    logic signed [DIV_W-1:0] div_num, div_den, div_q;

    rpcs_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_reg(prod));

    rpcs_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .num(div_num), .den(div_den),
        .done(div_done), .quo(div_q)
    );

    assign in_ch    = s_tuser[1:0];
    assign in_level = s_tuser[2];
    assign in_ts    = s_tdata[TIME_BITS-1:0];
    assign in_adc   = s_tdata[41:32];
    assign in_idx   = CH_W'(in_ch);
    assign in_acc   = s_tvalid && s_tready;
    assign in_w     = in_ts - start_reg[in_idx];
    assign in_w32   = 32'(in_w);
    assign in_valid = (in_w32 > ((in_ch == 2'd0) ? WIN_LOW_CH0 : WIN_LOW)) &&
                      (in_w32 < WIN_HIGH);

    assign w32     = 32'(w_reg);
    assign cz      = cal_reg[ch_reg][11:0];
    assign cf      = cal_reg[ch_reg][23:12];
    assign cg      = (ch_reg == 2'd3) ? CH3_SCALE : $signed(cal_reg[ch_reg][39:24]);
    assign wz_diff = $signed({2'b00, w32[11:0]}) - $signed({2'b00, cz});
    assign span    = $signed({2'b00, cf}) - $signed({2'b00, cz});
    assign pz      = power_reg[11:0];
    assign pm      = power_reg[23:12];
    assign rspan   = $signed({1'b0, pm}) - $signed({1'b0, pz});
    assign wm      = (w32 > 32'(MOTOR_W_MAX)) ? MOTOR_W_MAX : w32[15:0];
    assign wm_diff = $signed({2'b00, wm}) - $signed({6'b0, pz});
    assign raw     = valid_reg ? $signed(w32[12:0]) : RAW_INVALID;
    assign volt    = (rpm_mode_reg && ch_reg == 2'd3) ? 16'(adc_reg * VOLT_SCALE) : 16'd0;
    assign servo_fault = (span == 14'sd0);
    assign out_free    = !out_valid_reg || m_tready;

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_A_MUL:   begin mul_a = MUL_W'(wz_diff); mul_b = MUL_W'(cg); end
            S_M_N:     begin mul_a = MUL_W'(wm_diff); mul_b = MUL_W'(POWER_FULL); end
            S_M_D:     begin mul_a = MUL_W'(rspan); mul_b = MUL_W'({1'b0, adc_reg}); end
            S_M_PWAIT: begin mul_a = MUL_W'(CUR_DEN_K); mul_b = MUL_W'(d_reg); end
            S_M_CWAIT: begin mul_a = MUL_W'(RPM_A_K); mul_b = MUL_W'({1'b0, adc_reg}); end
            S_M_T2:    begin mul_a = MUL_W'(prod); mul_b = MUL_W'(d_reg); end
            S_M_T3:    begin mul_a = MUL_W'(RPM_N_K); mul_b = MUL_W'(n_reg); end
            S_M_DIFF:  begin mul_a = MUL_W'(RPM_DEN_K); mul_b = MUL_W'(d_reg); end
            default:   begin mul_a = '0; mul_b = '0; end
        endcase
    end

    always_comb
    begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        case (state_reg)
            S_A_DIV:
            begin
                div_start = !servo_fault;
                div_num   = prod <<< 8;
                div_den   = DIV_W'(span);
            end
            S_M_PDIV:
            begin
                div_start = (rspan != 13'sd0);
                div_num   = n_reg <<< 4;
                div_den   = DIV_W'(rspan);
            end
            S_M_CDIV:
            begin
                div_start = 1'b1;
                div_num   = n_reg <<< 13;
                div_den   = prod;
            end
            S_M_X19:
            begin
                div_start = 1'b1;
                div_num   = (diff_reg <<< 4) + (diff_reg <<< 1) + diff_reg;
                div_den   = prod;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        armed_next = armed_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_acc && (4'(in_ch) < 4'(CHANNELS)))
                begin
                    if (in_level)
                    begin
                        armed_next[in_idx] = 1'b1;
                    end
                    else if (armed_reg[in_idx])
                    begin
                        armed_next[in_idx] = 1'b0;
                        if (in_ch == 2'd3 && rpm_mode_reg)
                        begin
                            state_next = S_M_N;
                        end
                        else if (in_valid)
                        begin
                            state_next = S_A_MUL;
                        end
                        else
                        begin
                            state_next = S_FINISH;
                        end
                    end
                end
            end
            S_A_MUL:   state_next = S_A_DIV;
            S_A_DIV:   state_next = servo_fault ? S_FINISH : S_A_WAIT;
            S_A_WAIT:  state_next = div_done ? S_FINISH : S_A_WAIT;
            S_M_N:     state_next = S_M_D;
            S_M_D:     state_next = S_M_PDIV;
            S_M_PDIV:  state_next = (rspan == 13'sd0) ? S_FINISH : S_M_PWAIT;
            S_M_PWAIT:
            begin
                if (div_done)
                begin
                    state_next = (adc_reg == 10'd0) ? S_FINISH : S_M_CDIV;
                end
            end
            S_M_CDIV:  state_next = S_M_CWAIT;
            S_M_CWAIT: state_next = div_done ? S_M_T2 : S_M_CWAIT;
            S_M_T2:    state_next = S_M_T3;
            S_M_T3:    state_next = S_M_DIFF;
            S_M_DIFF:  state_next = S_M_X19;
            S_M_X19:   state_next = S_M_RWAIT;
            S_M_RWAIT: state_next = div_done ? S_FINISH : S_M_RWAIT;
            S_FINISH:  state_next = out_free ? S_IDLE : S_FINISH;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            armed_reg     <= '0;
            out_valid_reg <= 1'b0;
            cal_reg[0]    <= CAL0_RESET;
            cal_reg[1]    <= CAL_RESET;
            cal_reg[2]    <= CAL_RESET;
            cal_reg[3]    <= CAL_RESET;
            rpm_mode_reg  <= 1'b0;
            power_reg     <= POWER_RESET;
            for (int i = 0; i < CHANNELS; i++)
            begin
                start_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            armed_reg <= armed_next;
            if (in_acc && in_level && (4'(in_ch) < 4'(CHANNELS)))
            begin
                start_reg[in_idx] <= in_ts;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CAL0:     cal_reg[0]   <= cfg_data;
                    CFG_CAL1:     cal_reg[1]   <= cfg_data;
                    CFG_CAL2:     cal_reg[2]   <= cfg_data;
                    CFG_CAL3:     cal_reg[3]   <= cfg_data;
                    CFG_RPM_MODE: rpm_mode_reg <= cfg_data[0];
                    CFG_POWER:    power_reg    <= cfg_data[23:0];
                    default:      ;
                endcase
            end
            if (state_reg == S_FINISH && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                ch_reg        <= in_ch;
                w_reg         <= in_w;
                adc_reg       <= in_adc;
                valid_reg     <= in_valid;
                angle_reg     <= '0;
                power_out_reg <= '0;
                current_reg   <= '0;
                rpm_reg       <= '0;
                fault_reg     <= 1'b0;
            end
            S_A_DIV:   fault_reg <= servo_fault;
            S_A_WAIT:  if (div_done) angle_reg <= sat32(div_q);
            S_M_D:     n_reg <= prod;
            S_M_PDIV:
            begin
                d_reg     <= prod;
                fault_reg <= (rspan == 13'sd0);
            end
            S_M_PWAIT:
            begin
                if (div_done)
                begin
                    power_out_reg <= sat32(div_q);
                    fault_reg     <= (adc_reg == 10'd0);
                end
            end
            S_M_CWAIT: if (div_done) current_reg <= sat32(div_q);
            S_M_T3:    t2_reg <= prod;
            S_M_DIFF:  diff_reg <= t2_reg - (prod <<< 15);
            S_M_RWAIT: if (div_done) rpm_reg <= sat32(div_q);
            S_FINISH:
            begin
                if (out_free)
                begin
                    out_user_reg <= ch_reg;
                    out_data_reg <= {1'b0, fault_reg, rpm_reg, current_reg, power_out_reg,
                                     volt, angle_reg, valid_reg, raw};
                end
            end
            default:   ;
        endcase
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_A_WAIT || state_reg == S_M_PWAIT ||
                      state_reg == S_M_CWAIT || state_reg == S_M_RWAIT))
        else $error("divider finished outside a wait state");

    a_finish_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_valid_reg && !m_tready) |=> state_reg == S_FINISH)
        else $error("result dropped while output was full");

    a_valid_raw: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (!m_tdata[13] || !m_tdata[12]))
        else $error("valid pulse with negative width");

    a_invalid_angle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[13]) |-> (m_tdata[45:14] == 32'd0))
        else $error("nonzero angle on invalid pulse");

endmodule

[tb/sv/tb_rc_pulse_capture_and_scaling_core.sv]
module tb_rc_pulse_capture_and_scaling_core;
    timeunit 1ns;
    timeprecision 1ps;
    import rpcs_pkg::*;

    typedef struct packed {
        logic [1:0]         channel;
        logic               math_fault;
        logic signed [31:0] motor_rpm;
        logic signed [31:0] motor_current;
        logic signed [31:0] motor_power;
        logic [15:0]        motor_voltage;
        logic signed [31:0] angle;
        logic               pulse_valid;
        logic signed [12:0] raw_pulse;
    } pulse_result_t;

    class pulse_scoreboard;
        logic [39:0]   cal[4];
        logic          rpm_on;
        logic [23:0]   power_range;
        logic          armed[4];
        logic [31:0]   start_time[4];
        pulse_result_t pending[$];
        int            errors;

        function void reset_state();
            cal[0] = CAL0_RESET;
            cal[1] = CAL_RESET;
            cal[2] = CAL_RESET;
            cal[3] = CAL_RESET;
            rpm_on = 1'b0;
            power_range = POWER_RESET;
            for (int i = 0; i < 4; i++)
            begin
                armed[i] = 1'b0;
                start_time[i] = '0;
            end
            errors = 0;
        endfunction

        function void note_write(logic [CFG_IDX_W-1:0] idx, logic [39:0] value);
            case (idx)
                CFG_CAL0, CFG_CAL1, CFG_CAL2, CFG_CAL3: cal[idx[1:0]] = value;
                CFG_RPM_MODE: rpm_on = value[0];
                CFG_POWER:    power_range = value[23:0];
                default: ;
            endcase
        endfunction

        function longint clip32(longint v);
            if (v > 64'sd2147483647)
                return 64'sd2147483647;
            if (v < -64'sd2147483648)
                return -64'sd2147483648;
            return v;
        endfunction

        function void note_edge(logic [1:0] ch, logic level, logic [31:0] ts, logic [9:0] adc);
            pulse_result_t r;
            logic [31:0] w;
            longint lo, z, f, g, pz, pm, span, wm, n, a, d;
            logic valid;
            if (level)
            begin
                armed[ch] = 1'b1;
                start_time[ch] = ts;
                return;
            end
            if (!armed[ch])
                return;
            armed[ch] = 1'b0;
            w = ts - start_time[ch];
            lo = (ch == 2'd0) ? 64'sd950 : 64'sd700;
            valid = (w > lo) && (w < 2700);
            r = '0;
            r.channel = ch;
            r.pulse_valid = valid;
            r.raw_pulse = valid ? w[12:0] : RAW_INVALID;
            if (ch == 2'd3 && rpm_on)
            begin
                pz = longint'(power_range[11:0]);
                pm = longint'(power_range[23:12]);
                span = pm - pz;
                wm = (w > 32'd65535) ? 64'sd65535 : longint'(w);
                n = (wm - pz) * 2700;
                a = longint'(adc);
                r.motor_voltage = 16'(a * 50);
                if (span == 0)
                    r.math_fault = 1'b1;
                else
                begin
                    d = span * a;
                    r.motor_power = 32'(clip32(n * 16 / span));
                    if (a == 0)
                        r.math_fault = 1'b1;
                    else
                    begin
                        r.motor_current = 32'(clip32(n * 8192 / (25 * d)));
                        r.motor_rpm = 32'(clip32(19 * (78125 * a * d - 1212416 * n)
                                                 / (128000 * d)));
                    end
                end
            end
            else if (valid)
            begin
                z = longint'(cal[ch][11:0]);
                f = longint'(cal[ch][23:12]);
                g = (ch == 2'd3) ? 64'sd11500 : longint'($signed(cal[ch][39:24]));
                if (f == z)
                    r.math_fault = 1'b1;
                else
                    r.angle = 32'(clip32((longint'(w) - z) * g * 256 / (f - z)));
            end
            pending.push_back(r);
        endfunction

        function void check_beat(pulse_result_t got);
            pulse_result_t exp_r;
            if (pending.size() == 0)
            begin
                $display("%0t: unexpected result beat, actual %p", $time, got);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got !== exp_r)
            begin
                $display("%0t: mismatch, expected %p, actual %p", $time, exp_r, got);
                errors++;
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [47:0]        s_tdata;
    logic [2:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [159:0]       m_tdata;
    logic [1:0]         m_tuser;
    logic               cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]   cfg_data;

    pulse_scoreboard    board;
    logic               calm;
    int                 hold_off;

    rc_pulse_capture_and_scaling_core dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("Verification failed");
        $finish;
    end

    // Result side: random stalls, a long hold-off on request, checking at each beat.
    initial
    begin
        int gap;
        m_tready = 1'b0;
        gap = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                board.check_beat({m_tuser, m_tdata[158:0]});
            if (hold_off > 0)
            begin
                hold_off <= hold_off - 1;
                m_tready <= 1'b0;
            end
            else if (gap > 0)
            begin
                gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 9) == 0)
                    gap = $urandom_range(1, 13);
            end
        end
    end

    task automatic send_edge(logic [1:0] ch, logic level, logic [31:0] ts, logic [9:0] adc);
        if (!calm && $urandom_range(0, 7) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {level, ch};
        s_tdata <= {6'd0, adc, ts};
        do
            @(posedge clk);
        while (!s_tready);
        board.note_edge(ch, level, ts, adc);
    endtask

    task automatic send_pulse(logic [1:0] ch, logic [31:0] t0, logic [31:0] width,
                              logic [9:0] adc);
        send_edge(ch, 1'b1, t0, 10'($urandom));
        send_edge(ch, 1'b0, t0 + width, adc);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [39:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        board.note_write(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [31:0] pick_width();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 1000);
            2: return $urandom_range(690, 960);
            3: return $urandom_range(2690, 2710);
            4: return $urandom_range(2700, 70000);
            default: return $urandom_range(700, 2700);
        endcase
    endfunction

    task automatic random_phase(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 8)
                send_pulse(2'($urandom), $urandom, pick_width(),
                           ($urandom_range(0, 15) == 0) ? 10'd0 : 10'($urandom));
            else
                send_edge(2'($urandom), 1'($urandom), $urandom, 10'($urandom));
        end
    endtask

    function automatic logic [39:0] random_cal();
        logic [11:0] z;
        z = $urandom_range(0, 4095);
        case ($urandom_range(0, 5))
            0: return {16'($urandom), z, z};
            1: return {$urandom, 8'($urandom)};
            default: return {16'($urandom), 12'($urandom_range(1500, 2600)),
                             12'($urandom_range(700, 1400))};
        endcase
    endfunction

    initial
    begin
        board = new();
        board.reset_state();
        calm = 1'b0;
        hold_off = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_CAL0;
        cfg_data = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults, window edges, unarmed falls, restart, wrap.
        send_edge(2'd1, 1'b0, 32'd5, 10'd0);
        send_pulse(2'd0, 32'd100, 32'd950, 10'd0);
        send_pulse(2'd0, 32'd100, 32'd951, 10'd0);
        send_pulse(2'd1, 32'd0, 32'd700, 10'd0);
        send_pulse(2'd1, 32'd0, 32'd701, 10'd0);
        send_pulse(2'd2, 32'hFFFF_FF00, 32'd2699, 10'd0);
        send_pulse(2'd3, 32'hFFFF_FFFF, 32'd2700, 10'd1023);
        send_edge(2'd2, 1'b1, 32'd10, 10'd0);
        send_pulse(2'd2, 32'd20, 32'd1500, 10'd0);
        send_pulse(2'd0, 32'd0, 32'hFFFF_FFFF, 10'h3FF);
        drain();

        write_reg(CFG_CAL0, 40'hFF_FFFF_FFFF);
        write_reg(CFG_CAL1, {16'h7FFF, 12'd701, 12'd700});
        write_reg(CFG_CAL2, {16'h8000, 12'd0, 12'd4095});
        write_reg(CFG_CAL3, {16'h0000, 12'd1000, 12'd1000});
        send_pulse(2'd0, 32'd0, 32'd2000, 10'd0);
        send_pulse(2'd1, 32'd0, 32'd2699, 10'd0);
        send_pulse(2'd2, 32'd0, 32'd701, 10'd0);
        send_pulse(2'd3, 32'd0, 32'd1500, 10'd0);
        drain();

        write_reg(CFG_RPM_MODE, 40'd1);
        send_pulse(2'd3, 32'd0, 32'd1400, 10'd1023);
        send_pulse(2'd3, 32'd0, 32'd1400, 10'd0);
        send_pulse(2'd3, 32'd0, 32'd100000, 10'd1);
        send_pulse(2'd3, 32'd0, 32'd10, 10'd512);
        drain();
        write_reg(CFG_POWER, {12'd500, 12'd500});
        send_pulse(2'd3, 32'd0, 32'd1400, 10'd300);
        drain();
        write_reg(CFG_POWER, 40'hFF_FFFF);
        write_reg(CFG_POWER, {12'd0, 12'd4095});
        send_pulse(2'd3, 32'd0, 32'd4000, 10'd1);
        drain();

        // Long receiver hold-off while items keep arriving.
        hold_off = 600;
        random_phase(30);
        drain();

        for (int p = 0; p < 8; p++)
        begin
            for (int r = 0; r < 4; r++)
                write_reg(CFG_IDX_W'(CFG_CAL0 + r), random_cal());
            write_reg(CFG_RPM_MODE, 40'($urandom_range(0, 1)));
            write_reg(CFG_POWER, ($urandom_range(0, 7) == 0) ? 40'($urandom)
                      : {16'd0, 12'($urandom_range(1500, 2500)),
                         12'($urandom_range(700, 1300))});
            random_phase(45);
            drain();
        end

        calm = 1'b1;
        random_phase(40);
        drain();

        if (board.errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end
endmodule

[sim.f]
design/rpcs_pkg.sv
design/rpcs_mul.sv
design/rpcs_div.sv
design/rc_pulse_capture_and_scaling_core.sv
tb/sv/tb_rc_pulse_capture_and_scaling_core.sv
